[src/cfcr_pkg.sv]
// Shared types, constants and the CRC byte update for the framed command receiver.
`timescale 1ns / 1ps
`default_nettype none

package cfcr_pkg;

  localparam int CNT_W      = 7;
  localparam int HEAD_DEPTH = 5;

  localparam logic [CNT_W-1:0] MAX_FRAME  = 7'd64;
  localparam logic [CNT_W-1:0] MIN_LEN_LO = 7'd2;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [15:0]      TIMEOUT_RESET = 16'd1000;
  localparam logic [CNT_W-1:0] MIN_LEN_RESET = 7'd4;

  localparam logic [7:0] FUNC_LIGHT = 8'h01;
  localparam logic [7:0] FUNC_PWM   = 8'h02;

  // Input kind carried on the slave tuser bit.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MIN_LEN = 1'b1;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_OK    = 3'd1,
    ST_CRC   = 3'd2,
    ST_SHORT = 3'd3,
    ST_OVF   = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0]      timeout_ms;
    logic [CNT_W-1:0] min_len;
  } cfg_t;

  typedef struct packed {
    status_t     frame_status;
    logic [15:0] error_total;
    logic [15:0] servo_second;
    logic [15:0] servo_first;
    logic [7:0]  light_bits;
  } result_t;

  // Reflected CRC-16 update by one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/cfcr_frame.sv]
// Frame assembly, CRC check, command registers, error counter and silence timer.
`timescale 1ns / 1ps
`default_nettype none

module cfcr_frame (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire cfcr_pkg::cfg_t    cfg,
  input  wire logic              op,
  input  wire logic [7:0]        data_byte,
  input  wire logic              eof,
  output cfcr_pkg::result_t      result
);

  logic [15:0]                crc, crc_next;
  logic [cfcr_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                       ovf, ovf_next;
  logic [7:0]                 tb0, tb0_next, tb1, tb1_next;
  logic [7:0]                 head [cfcr_pkg::HEAD_DEPTH];
  logic [7:0]                 head_next [cfcr_pkg::HEAD_DEPTH];
  logic [7:0]                 light, light_next;
  logic [15:0]                servo1, servo1_next, servo2, servo2_next;
  logic [15:0]                err, err_next;
  logic [15:0]                silence, silence_next;
  logic [cfcr_pkg::CNT_W-1:0] min_len;
  cfcr_pkg::status_t          status;

  always_comb begin
    crc_next     = crc;
    cnt_next     = cnt;
    ovf_next     = ovf;
    tb0_next     = tb0;
    tb1_next     = tb1;
    head_next    = head;
    light_next   = light;
    servo1_next  = servo1;
    servo2_next  = servo2;
    err_next     = err;
    silence_next = silence;
    status       = cfcr_pkg::ST_NONE;
    // Two bytes are always needed for the CRC itself.
    min_len = (cfg.min_len < cfcr_pkg::MIN_LEN_LO) ? cfcr_pkg::MIN_LEN_LO : cfg.min_len;

    if (op == cfcr_pkg::OP_BYTE) begin
      if (!ovf) begin
        if (cnt >= cfcr_pkg::MAX_FRAME) begin
          ovf_next = 1'b1;
        end else begin
          // The byte two places back is no longer a CRC candidate, so it joins the sum.
          if (cnt >= cfcr_pkg::CNT_W'(2)) begin
            crc_next = cfcr_pkg::crc_byte(crc, tb0);
          end
          tb0_next = tb1;
          tb1_next = data_byte;
          for (int i = 0; i < cfcr_pkg::HEAD_DEPTH; i++) begin
            if (cnt == cfcr_pkg::CNT_W'(i)) begin
              head_next[i] = data_byte;
            end
          end
          cnt_next = cnt + 1'b1;
        end
      end

      if (eof) begin
        if (ovf_next) begin
          status = cfcr_pkg::ST_OVF;
        end else if (cnt_next < min_len) begin
          status = cfcr_pkg::ST_SHORT;
        end else if (crc_next == {tb0_next, tb1_next}) begin
          status = cfcr_pkg::ST_OK;
          if (head_next[0] == cfcr_pkg::FUNC_LIGHT) begin
            light_next = head_next[1];
          end else if (head_next[0] == cfcr_pkg::FUNC_PWM) begin
            servo1_next = {head_next[1], head_next[2]};
            servo2_next = {head_next[3], head_next[4]};
          end
          silence_next = 16'd0;
        end else begin
          status = cfcr_pkg::ST_CRC;
        end
        if (status != cfcr_pkg::ST_OK) begin
          err_next = err + 16'd1;
        end
        crc_next = cfcr_pkg::CRC_INIT;
        cnt_next = '0;
        ovf_next = 1'b0;
        tb0_next = 8'h00;
        tb1_next = 8'h00;
        for (int i = 0; i < cfcr_pkg::HEAD_DEPTH; i++) begin
          head_next[i] = 8'h00;
        end
      end
    end else if (silence < cfg.timeout_ms) begin
      silence_next = silence + 16'd1;
    end

    if (silence_next >= cfg.timeout_ms) begin
      light_next  = 8'h00;
      servo1_next = 16'd0;
      servo2_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= cfcr_pkg::CRC_INIT;
      cnt     <= '0;
      ovf     <= 1'b0;
      tb0     <= 8'h00;
      tb1     <= 8'h00;
      for (int i = 0; i < cfcr_pkg::HEAD_DEPTH; i++) begin
        head[i] <= 8'h00;
      end
      light   <= 8'h00;
      servo1  <= 16'd0;
      servo2  <= 16'd0;
      err     <= 16'd0;
      silence <= 16'd0;
    end else if (take) begin
      crc     <= crc_next;
      cnt     <= cnt_next;
      ovf     <= ovf_next;
      tb0     <= tb0_next;
      tb1     <= tb1_next;
      head    <= head_next;
      light   <= light_next;
      servo1  <= servo1_next;
      servo2  <= servo2_next;
      err     <= err_next;
      silence <= silence_next;
    end
  end

  always_comb begin
    result.frame_status = status;
    result.error_total  = err_next;
    result.servo_second = servo2_next;
    result.servo_first  = servo1_next;
    result.light_bits   = light_next;
  end

`ifndef SYNTHESIS
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    take && (op == cfcr_pkg::OP_BYTE) && eof |=> (cnt == '0) && !ovf && (crc == cfcr_pkg::CRC_INIT))
    else $error("frame state not cleared after end of frame");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (cnt == cfcr_pkg::MAX_FRAME))
    else $error("overflow flag set before the frame buffer was full");

  a_err_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (err != $past(err)) |-> (err == $past(err) + 16'd1) && $past(take))
    else $error("error counter moved by more than one");
`endif

endmodule

`default_nettype wire

[src/cfcr_out_buf.sv]
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module cfcr_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cfcr_pkg::result_t  in_result,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cfcr_pkg::result_t       out_result
);

  logic              skid_valid;
  cfcr_pkg::result_t skid;
  logic              take;

  assign in_ready = !skid_valid;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      // Output is stalled; park a new result in the skid register.
      if (take) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (take) begin
        skid <= in_result;
      end
    end else if (skid_valid) begin
      out_result <= skid;
    end else if (take) begin
      out_result <= in_result;
    end
  end

endmodule

`default_nettype wire

[src/crc16_framed_command_receiver_top.sv]
// Top level of the CRC-16 framed command receiver.
//
// Slave stream: one transaction per received byte or millisecond tick. tuser is
// the kind (0 byte, 1 tick), tdata the byte, tlast marks the last byte of a frame.
// Master stream: exactly one result transaction per input transaction, carrying
// the light bits, both servo values, the bad-frame count and the frame status
// after that input has been handled.
// Each input is processed in the cycle it is accepted; its result is registered in
// the result register, or in the skid register while the master side stalls. One
// item can be taken every cycle while the skid register is empty.
// A two-entry output buffer lets one more input be accepted while a result waits;
// when both entries are full, s_tready drops and comes back in the cycle after
// the receiver takes a result.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 timeout_ms,
// 1 min_frame_len) on the clock edge; write only while the block is idle.
// Reset (rst, synchronous) sets timeout 1000 ms, minimum length 4, clears
// outputs, counters and the partial frame, and empties the output buffer.
`timescale 1ns / 1ps
`default_nettype none

module crc16_framed_command_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] op
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [7:0] light_bits, [23:8] servo_first,
                                      // [39:24] servo_second, [55:40] error_total,
                                      // [58:56] frame_status, [63:59] zero
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfcr_pkg::cfg_t    cfg;
  cfcr_pkg::result_t step_result;
  cfcr_pkg::result_t out_result;
  logic              take;

  assign take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms <= cfcr_pkg::TIMEOUT_RESET;
      cfg.min_len    <= cfcr_pkg::MIN_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfcr_pkg::REG_TIMEOUT: cfg.timeout_ms <= cfg_data;
        cfcr_pkg::REG_MIN_LEN: cfg.min_len    <= cfg_data[cfcr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  cfcr_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cfg       (cfg),
    .op        (s_tuser),
    .data_byte (s_tdata),
    .eof       (s_tlast),
    .result    (step_result)
  );

  cfcr_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_result  (step_result),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  assign m_tdata = {5'b00000, out_result.frame_status, out_result.error_total,
                    out_result.servo_second, out_result.servo_first,
                    out_result.light_bits};

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the CRC-16 framed command receiver.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES = 6;

  typedef enum logic [1:0] {SRC_DATA, SRC_CRC_HI, SRC_CRC_LO, SRC_CRC_BAD} byte_src_t;

  typedef struct {
    logic              op;
    byte_src_t         src;
    logic [7:0]        val;
    logic              eof;
    logic              typed;
    cfcr_pkg::result_t want;
  } drow_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] op
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [7:0] light_bits, [23:8] servo_first,
                                  // [39:24] servo_second, [55:40] error_total,
                                  // [58:56] frame_status
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  crc16_framed_command_receiver_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Receiver state as the testbench sees it.
  logic [15:0] cur_timeout = cfcr_pkg::TIMEOUT_RESET;
  logic [6:0]  cur_min_len = cfcr_pkg::MIN_LEN_RESET;
  logic [15:0] crc_acc = cfcr_pkg::CRC_INIT;
  logic [6:0]  byte_cnt = '0;
  logic        ovf = 1'b0;
  logic [7:0]  tail [2] = '{8'h00, 8'h00};
  logic [7:0]  head [cfcr_pkg::HEAD_DEPTH] = '{default: 8'h00};
  logic [7:0]  light = 8'h00;
  logic [15:0] servo_a = 16'h0000;
  logic [15:0] servo_b = 16'h0000;
  logic [15:0] err_cnt = 16'h0000;
  logic [15:0] silence = 16'h0000;

  cfcr_pkg::result_t pending_outputs [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic    hold_req = 1'b0;
  logic    hold_ack = 1'b0;
  int      hold_left = 0;
  int unsigned cycle_count = 0;

  // Reflected CRC-16, one data bit folded in per shift.
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ d[k]) ? ((r >> 1) ^ cfcr_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic cfcr_pkg::result_t res(input logic [7:0] l, input logic [15:0] s1,
                                            input logic [15:0] s2, input logic [15:0] e,
                                            input cfcr_pkg::status_t st);
    cfcr_pkg::result_t r;
    r.light_bits   = l;
    r.servo_first  = s1;
    r.servo_second = s2;
    r.error_total  = e;
    r.frame_status = st;
    return r;
  endfunction

  function automatic drow_t row(input logic op, input byte_src_t src, input logic [7:0] v,
                                input logic eof, input logic typed,
                                input cfcr_pkg::result_t want);
    drow_t d;
    d.op = op;
    d.src = src;
    d.val = v;
    d.eof = eof;
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  // Advances the receiver state by one item and returns the outputs after it.
  function automatic void predict_outputs(input logic op, input logic [7:0] b,
                                          input logic eof, output cfcr_pkg::result_t r);
    cfcr_pkg::status_t st;
    logic [6:0] eff_min;
    st = cfcr_pkg::ST_NONE;
    if (op == cfcr_pkg::OP_BYTE) begin
      if (!ovf) begin
        if (byte_cnt >= cfcr_pkg::MAX_FRAME) begin
          ovf = 1'b1;
        end else begin
          // The two newest bytes are held back as the received CRC.
          if (byte_cnt >= 2) crc_acc = crc16_step(crc_acc, tail[0]);
          tail[0] = tail[1];
          tail[1] = b;
          if (byte_cnt < cfcr_pkg::HEAD_DEPTH) head[byte_cnt[2:0]] = b;
          byte_cnt = byte_cnt + 7'd1;
        end
      end
      if (eof) begin
        eff_min = (cur_min_len < cfcr_pkg::MIN_LEN_LO) ? cfcr_pkg::MIN_LEN_LO : cur_min_len;
        if (ovf) begin
          st = cfcr_pkg::ST_OVF;
        end else if (byte_cnt < eff_min) begin
          st = cfcr_pkg::ST_SHORT;
        end else if (crc_acc == {tail[0], tail[1]}) begin
          st = cfcr_pkg::ST_OK;
          case (head[0])
            cfcr_pkg::FUNC_LIGHT: begin
              light = head[1];
            end
            cfcr_pkg::FUNC_PWM: begin
              servo_a = {head[1], head[2]};
              servo_b = {head[3], head[4]};
            end
            default: begin
            end
          endcase
          silence = 16'h0000;
        end else begin
          st = cfcr_pkg::ST_CRC;
        end
        if (st != cfcr_pkg::ST_OK) err_cnt = err_cnt + 16'd1;
        crc_acc = cfcr_pkg::CRC_INIT;
        byte_cnt = '0;
        ovf = 1'b0;
        tail = '{8'h00, 8'h00};
        head = '{default: 8'h00};
      end
    end else if (silence < cur_timeout) begin
      silence = silence + 16'd1;
    end
    if (silence >= cur_timeout) begin
      light = 8'h00;
      servo_a = 16'h0000;
      servo_b = 16'h0000;
    end
    r = res(light, servo_a, servo_b, err_cnt, st);
  endfunction

  task automatic offer(input logic op, input logic [7:0] b, input logic eof,
                       input logic use_typed, input cfcr_pkg::result_t typed);
    cfcr_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    s_tlast  <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_outputs(op, b, eof, r);
    pending_outputs.push_back(use_typed ? typed : r);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] timeout, input logic [6:0] min_len);
    cfg_we    <= 1'b1;
    cfg_index <= cfcr_pkg::REG_TIMEOUT;
    cfg_data  <= timeout;
    @(posedge clk);
    cfg_index <= cfcr_pkg::REG_MIN_LEN;
    cfg_data  <= {9'd0, min_len};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_timeout = timeout;
    cur_min_len = min_len;
  endtask

  // One random unit: ticks, a well-formed frame, a broken frame or loose noise.
  task automatic send_random_unit(input int long_pct);
    logic [7:0] fb [$];
    logic [15:0] c;
    int pick, n, fsel, idx;
    pick = $urandom_range(99);
    c = cfcr_pkg::CRC_INIT;
    if (pick < 15) begin
      repeat ($urandom_range(1, 4))
        offer(cfcr_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
    end else if (pick < 65 || (pick >= 76 && pick < 76 + long_pct)) begin
      if (pick >= 76) begin
        n = int'(cfcr_pkg::MAX_FRAME) - 2;
      end else begin
        fsel = $urandom_range(9);
        if (fsel == 0) n = 0;
        else if (fsel < 7) n = $urandom_range(1, 7);
        else if (fsel < 9) n = $urandom_range(1, 14);
        else n = $urandom_range(1, int'(cfcr_pkg::MAX_FRAME) - 2);
      end
      for (int i = 0; i < n; i++) begin
        if (i == 0) begin
          fsel = $urandom_range(9);
          fb.push_back(fsel < 4 ? cfcr_pkg::FUNC_LIGHT :
                       fsel < 8 ? cfcr_pkg::FUNC_PWM : 8'($urandom));
        end else begin
          fb.push_back(8'($urandom));
        end
        c = crc16_step(c, fb[i]);
      end
      fb.push_back(c[15:8]);
      fb.push_back(c[7:0]);
      if ($urandom_range(9) == 0) begin
        idx = $urandom_range(fb.size() - 1);
        fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(7));
      end
    end else if (pick < 73) begin
      repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
    end else if (pick < 76) begin
      repeat ($urandom_range(int'(cfcr_pkg::MAX_FRAME) + 1, int'(cfcr_pkg::MAX_FRAME) + 4))
        fb.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6))
        offer(1'($urandom), 8'($urandom), $urandom_range(9) < 3, 1'b0, '0);
    end
    foreach (fb[i]) offer(cfcr_pkg::OP_BYTE, fb[i], i == fb.size() - 1, 1'b0, '0);
  endtask

  task automatic note_mismatch(input string field, input logic [15:0] e, input logic [15:0] a);
    mismatch_count++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, e, a);
  endtask

  // Output side: checks each transaction.
  always @(posedge clk) begin
    cfcr_pkg::result_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got = cfcr_pkg::result_t'(m_tdata[58:0]);
      if (pending_outputs.size() == 0) begin
        note_mismatch("unexpected transaction", 16'h0000, {8'h00, got.light_bits});
      end else begin
        exp = pending_outputs.pop_front();
        if (got.light_bits !== exp.light_bits)
          note_mismatch("light_bits", {8'h00, exp.light_bits}, {8'h00, got.light_bits});
        if (got.servo_first !== exp.servo_first)
          note_mismatch("servo_first", exp.servo_first, got.servo_first);
        if (got.servo_second !== exp.servo_second)
          note_mismatch("servo_second", exp.servo_second, got.servo_second);
        if (got.error_total !== exp.error_total)
          note_mismatch("error_total", exp.error_total, got.error_total);
        if (got.frame_status !== exp.frame_status)
          note_mismatch("frame_status", 16'(exp.frame_status), 16'(got.frame_status));
      end
    end
  end

  // Receiver side: a hold request keeps tready low for a long stretch of cycles.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    drow_t dir_rows [25];
    logic [15:0] run_crc;
    logic [7:0] v;
    int phase_timeout [PHASES];
    int phase_min_len [PHASES];
    int phase_items [PHASES];
    int phase_long [PHASES];
    int target;

    phase_timeout = '{1000, 1, 7, 0, 65535, 20};
    phase_min_len = '{4, 3, 0, 127, 64, 1};
    phase_items   = '{85, 65, 65, 30, 80, 50};
    phase_long    = '{3, 3, 3, 3, 30, 3};

    dir_rows = '{
      row(cfcr_pkg::OP_TICK, SRC_DATA, 8'h00, 1'b0, 1'b1,
          res(8'h00, 16'h0, 16'h0, 16'd0, cfcr_pkg::ST_NONE)),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'hFF, 1'b1, 1'b1,
          res(8'h00, 16'h0, 16'h0, 16'd1, cfcr_pkg::ST_SHORT)),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'h00, 1'b0, 1'b1,
          res(8'h00, 16'h0, 16'h0, 16'd1, cfcr_pkg::ST_NONE)),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'h00, 1'b1, 1'b1,
          res(8'h00, 16'h0, 16'h0, 16'd2, cfcr_pkg::ST_SHORT)),
      // Light command with all bits set.
      row(cfcr_pkg::OP_BYTE, SRC_DATA, cfcr_pkg::FUNC_LIGHT, 1'b0, 1'b1,
          res(8'h00, 16'h0, 16'h0, 16'd2, cfcr_pkg::ST_NONE)),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'hFF, 1'b0, 1'b1,
          res(8'h00, 16'h0, 16'h0, 16'd2, cfcr_pkg::ST_NONE)),
      row(cfcr_pkg::OP_BYTE, SRC_CRC_HI, 8'h00, 1'b0, 1'b1,
          res(8'h00, 16'h0, 16'h0, 16'd2, cfcr_pkg::ST_NONE)),
      row(cfcr_pkg::OP_BYTE, SRC_CRC_LO, 8'h00, 1'b1, 1'b1,
          res(8'hFF, 16'h0, 16'h0, 16'd2, cfcr_pkg::ST_OK)),
      // Same command with a damaged CRC must leave the lights alone.
      row(cfcr_pkg::OP_BYTE, SRC_DATA, cfcr_pkg::FUNC_LIGHT, 1'b0, 1'b1,
          res(8'hFF, 16'h0, 16'h0, 16'd2, cfcr_pkg::ST_NONE)),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'h00, 1'b0, 1'b1,
          res(8'hFF, 16'h0, 16'h0, 16'd2, cfcr_pkg::ST_NONE)),
      row(cfcr_pkg::OP_BYTE, SRC_CRC_HI, 8'h00, 1'b0, 1'b1,
          res(8'hFF, 16'h0, 16'h0, 16'd2, cfcr_pkg::ST_NONE)),
      row(cfcr_pkg::OP_BYTE, SRC_CRC_BAD, 8'h00, 1'b1, 1'b1,
          res(8'hFF, 16'h0, 16'h0, 16'd3, cfcr_pkg::ST_CRC)),
      // Servo command, first value all ones and second all zeros.
      row(cfcr_pkg::OP_BYTE, SRC_DATA, cfcr_pkg::FUNC_PWM, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'hFF, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'hFF, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'h00, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'h00, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_CRC_HI, 8'h00, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_CRC_LO, 8'h00, 1'b1, 1'b1,
          res(8'hFF, 16'hFFFF, 16'h0, 16'd3, cfcr_pkg::ST_OK)),
      // Servo command so short that the CRC bytes land in the servo values.
      row(cfcr_pkg::OP_BYTE, SRC_DATA, cfcr_pkg::FUNC_PWM, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'h12, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_CRC_HI, 8'h00, 1'b0, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_CRC_LO, 8'h00, 1'b1, 1'b0, '0),
      // A tick ignores its data and end flag.
      row(cfcr_pkg::OP_TICK, SRC_DATA, 8'hFF, 1'b1, 1'b0, '0),
      row(cfcr_pkg::OP_BYTE, SRC_DATA, 8'h80, 1'b1, 1'b0, '0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 75;
    run_crc = cfcr_pkg::CRC_INIT;
    foreach (dir_rows[i]) begin
      v = dir_rows[i].val;
      case (dir_rows[i].src)
        SRC_CRC_HI:  v = run_crc[15:8];
        SRC_CRC_LO:  v = run_crc[7:0];
        SRC_CRC_BAD: v = run_crc[7:0] ^ 8'h01;
        default: begin
        end
      endcase
      offer(dir_rows[i].op, v, dir_rows[i].eof, dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].op == cfcr_pkg::OP_BYTE) begin
        if (dir_rows[i].eof) run_crc = cfcr_pkg::CRC_INIT;
        else if (dir_rows[i].src == SRC_DATA) run_crc = crc16_step(run_crc, v);
      end
    end
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      configure(16'(phase_timeout[p]), 7'(phase_min_len[p]));
      case (p % 3)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Stall the output early on so the input side backs up.
      if (p == 0) hold_req <= ~hold_req;
      target = items_sent + phase_items[p];
      while (items_sent < target) send_random_unit(phase_long[p]);
      wait_idle();
    end

    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
